// File: rtl/qsq_pkg.sv
`timescale 1ns / 1ps

package qsq_pkg;

	// pipeline depth from input register to result register
	localparam int NSTAGES = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_NARROW_W = 8;
	localparam int MIN_AREA_W = 24;
	localparam int SQ_W       = 2 * CFG_NARROW_W;

	// result area field
	localparam int AREA_W = 25;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	// register reset values
	localparam logic [CFG_NARROW_W-1:0] RST_COS_NUM   = 8'd1;
	localparam logic [CFG_NARROW_W-1:0] RST_COS_DEN   = 8'd4;
	localparam logic [CFG_NARROW_W-1:0] RST_RATIO_NUM = 8'd6;
	localparam logic [CFG_NARROW_W-1:0] RST_RATIO_DEN = 8'd5;
	localparam logic [MIN_AREA_W-1:0]   RST_MIN_AREA  = 24'd900;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_NUM   = 3'd0,
		REG_COS_DEN   = 3'd1,
		REG_RATIO_NUM = 3'd2,
		REG_RATIO_DEN = 3'd3,
		REG_MIN_AREA  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		REASON_OK     = 3'd0,
		REASON_CONVEX = 3'd1,
		REASON_ANGLE  = 3'd2,
		REASON_RATIO  = 3'd3,
		REASON_SMALL  = 3'd4
	} reason_t;

	// limits in the form the datapath consumes them
	typedef struct packed {
		logic [SQ_W-1:0]   cos_num_sq;
		logic [SQ_W-1:0]   cos_den_sq;
		logic [SQ_W-1:0]   ratio_num_sq;
		logic [SQ_W-1:0]   ratio_den_sq;
		logic [AREA_W-1:0] min_area2;
	} cfg_t;

	// per-stage load enables
	typedef struct packed {
		logic [NSTAGES-1:0] adv;
	} pipe_ctl_t;

endpackage

// File: rtl/qsq_if.sv
`timescale 1ns / 1ps

// one quadrilateral per transaction
interface qsq_in_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] x0;
	logic [COORD_BITS-1:0] y0;
	logic [COORD_BITS-1:0] x1;
	logic [COORD_BITS-1:0] y1;
	logic [COORD_BITS-1:0] x2;
	logic [COORD_BITS-1:0] y2;
	logic [COORD_BITS-1:0] x3;
	logic [COORD_BITS-1:0] y3;

	modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
	modport sink (input valid, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

// one verdict per transaction
interface qsq_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  reject_reason;
	logic [24:0] area_doubled;

	modport source (output valid, accepted, reject_reason, area_doubled, input ready);
	modport sink (input valid, accepted, reject_reason, area_doubled, output ready);
endinterface

// File: rtl/qsq_regs.sv
`timescale 1ns / 1ps

module qsq_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output qsq_pkg::cfg_t                  cfg
);
	import qsq_pkg::*;

	logic [CFG_NARROW_W-1:0] cos_num_q;
	logic [CFG_NARROW_W-1:0] cos_den_q;
	logic [CFG_NARROW_W-1:0] ratio_num_q;
	logic [CFG_NARROW_W-1:0] ratio_den_q;
	logic [MIN_AREA_W-1:0]   min_area_q;
	cfg_t                    cfg_q;

	// take register writes, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_num_q   <= RST_COS_NUM;
			cos_den_q   <= RST_COS_DEN;
			ratio_num_q <= RST_RATIO_NUM;
			ratio_den_q <= RST_RATIO_DEN;
			min_area_q  <= RST_MIN_AREA;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COS_NUM:   cos_num_q   <= cfg_wdata[CFG_NARROW_W-1:0];
				REG_COS_DEN:   cos_den_q   <= cfg_wdata[CFG_NARROW_W-1:0];
				REG_RATIO_NUM: ratio_num_q <= cfg_wdata[CFG_NARROW_W-1:0];
				REG_RATIO_DEN: ratio_den_q <= cfg_wdata[CFG_NARROW_W-1:0];
				REG_MIN_AREA:  min_area_q  <= cfg_wdata[MIN_AREA_W-1:0];
				default: ;
			endcase
		end
	end

	// hold squared limits and doubled area floor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_num_sq   <= SQ_W'(RST_COS_NUM) * SQ_W'(RST_COS_NUM);
			cfg_q.cos_den_sq   <= SQ_W'(RST_COS_DEN) * SQ_W'(RST_COS_DEN);
			cfg_q.ratio_num_sq <= SQ_W'(RST_RATIO_NUM) * SQ_W'(RST_RATIO_NUM);
			cfg_q.ratio_den_sq <= SQ_W'(RST_RATIO_DEN) * SQ_W'(RST_RATIO_DEN);
			cfg_q.min_area2    <= {RST_MIN_AREA, 1'b0};
		end else begin
			cfg_q.cos_num_sq   <= SQ_W'(cos_num_q) * SQ_W'(cos_num_q);
			cfg_q.cos_den_sq   <= SQ_W'(cos_den_q) * SQ_W'(cos_den_q);
			cfg_q.ratio_num_sq <= SQ_W'(ratio_num_q) * SQ_W'(ratio_num_q);
			cfg_q.ratio_den_sq <= SQ_W'(ratio_den_q) * SQ_W'(ratio_den_q);
			cfg_q.min_area2    <= {min_area_q, 1'b0};
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/qsq_geom.sv
`timescale 1ns / 1ps

module qsq_geom #(
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  qsq_pkg::pipe_ctl_t                  ctl,
	input  logic [3:0][COORD_BITS-1:0]          px,
	input  logic [3:0][COORD_BITS-1:0]          py,
	output logic [3:0][2*COORD_BITS:0]          side_s2,
	output logic [2:0][2*COORD_BITS:0]          dmag_s2,
	output logic [2*COORD_BITS:0]               area_s2,
	output logic                                conv_fail_s2
);
	import qsq_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 1;
	localparam int MW = 2 * DW;
	localparam int XW = MW + 1;

	logic signed [3:0][DW-1:0] ex_d, ey_d;
	logic signed [3:0][DW-1:0] ex_s1, ey_s1;
	logic signed [1:0][DW-1:0] gx_d, gy_d;
	logic signed [1:0][DW-1:0] gx_s1, gy_s1;

	logic [3:0]         cpos, cneg;
	logic [3:0][PW-1:0] side_d;
	logic [2:0][PW-1:0] dmag_d;
	logic [PW-1:0]      area_d;

	// edge vectors and diagonals
	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_edge
			assign ex_d[g] = $signed({1'b0, px[(g + 1) % 4]}) - $signed({1'b0, px[g]});
			assign ey_d[g] = $signed({1'b0, py[(g + 1) % 4]}) - $signed({1'b0, py[g]});
		end
		for (g = 0; g < 2; g++) begin : g_diag
			assign gx_d[g] = $signed({1'b0, px[g + 2]}) - $signed({1'b0, px[g]});
			assign gy_d[g] = $signed({1'b0, py[g + 2]}) - $signed({1'b0, py[g]});
		end
	endgenerate

	// stage 1: register differences
	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			ex_s1 <= ex_d;
			ey_s1 <= ey_d;
			gx_s1 <= gx_d;
			gy_s1 <= gy_d;
		end
	end

	// turn direction at every corner, squared side lengths
	generate
		for (g = 0; g < 4; g++) begin : g_corner
			logic signed [MW-1:0] pa, pb, sx, sy;
			logic signed [XW-1:0] cr;
			assign pa = $signed(ex_s1[(g + 3) % 4]) * $signed(ey_s1[g]);
			assign pb = $signed(ey_s1[(g + 3) % 4]) * $signed(ex_s1[g]);
			assign cr = XW'(pa) - XW'(pb);
			assign cpos[g] = !cr[XW-1] && (|cr);
			assign cneg[g] = cr[XW-1];
			assign sx = $signed(ex_s1[g]) * $signed(ex_s1[g]);
			assign sy = $signed(ey_s1[g]) * $signed(ey_s1[g]);
			assign side_d[g] = PW'(sx) + PW'(sy);
		end

		// corner dot product magnitudes at vertices one to three
		for (g = 0; g < 3; g++) begin : g_dot
			logic signed [MW-1:0] qx, qy;
			logic signed [XW-1:0] dt, dneg;
			assign qx = $signed(ex_s1[g + 1]) * $signed(ex_s1[g]);
			assign qy = $signed(ey_s1[g + 1]) * $signed(ey_s1[g]);
			assign dt = XW'(qx) + XW'(qy);
			assign dneg = -dt;
			assign dmag_d[g] = dt[XW-1] ? PW'(dneg) : PW'(dt);
		end
	endgenerate

	// shoelace sum as cross product of the diagonals
	logic signed [MW-1:0] ga, gb;
	logic signed [XW-1:0] shoe, shoe_neg;
	assign ga = $signed(gx_s1[0]) * $signed(gy_s1[1]);
	assign gb = $signed(gy_s1[0]) * $signed(gx_s1[1]);
	assign shoe = XW'(ga) - XW'(gb);
	assign shoe_neg = -shoe;
	assign area_d = shoe[XW-1] ? PW'(shoe_neg) : PW'(shoe);

	// stage 2: register first products
	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			side_s2      <= side_d;
			dmag_s2      <= dmag_d;
			area_s2      <= area_d;
			conv_fail_s2 <= (|cpos) && (|cneg);
		end
	end

endmodule

// File: rtl/qsq_prod.sv
`timescale 1ns / 1ps

module qsq_prod #(
	parameter int COORD_BITS = 12
) (
	input  logic                                                 clk,
	input  qsq_pkg::pipe_ctl_t                                   ctl,
	input  qsq_pkg::cfg_t                                        cfg,
	input  logic [3:0][2*COORD_BITS:0]                           side_s2,
	input  logic [2:0][2*COORD_BITS:0]                           dmag_s2,
	input  logic [2*COORD_BITS:0]                                area_s2,
	input  logic                                                 conv_fail_s2,
	output logic [2:0][2*(2*COORD_BITS+1)+qsq_pkg::SQ_W-1:0]     lhs_s4,
	output logic [2:0][2*(2*COORD_BITS+1)+qsq_pkg::SQ_W-1:0]     rhs_s4,
	output logic [2*COORD_BITS+qsq_pkg::SQ_W:0]                  rl_s4,
	output logic [2*COORD_BITS+qsq_pkg::SQ_W:0]                  rr_s4,
	output logic [qsq_pkg::AREA_W-1:0]                           area_s4,
	output logic                                                 conv_fail_s4,
	output logic                                                 small_s4
);
	import qsq_pkg::*;

	localparam int PW = 2 * COORD_BITS + 1;
	localparam int LW = 2 * PW;
	localparam int HW = LW + SQ_W;
	localparam int RW = PW + SQ_W;
	localparam int CW = (PW > AREA_W) ? PW : AREA_W;

	logic [2:0][LW-1:0] dsq_d, lprod_d;
	logic [2:0][LW-1:0] dsq_s3, lprod_s3;
	logic [PW-1:0]      max01, max23, min01, min23;
	logic [PW-1:0]      smax_s3, smin_s3;
	logic [CW-1:0]      area_ext;
	logic [AREA_W-1:0]  area_s3;
	logic               small_s3, conv_fail_s3;

	// squared dot products and products of adjacent squared sides
	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_sq
			assign dsq_d[g]   = LW'(dmag_s2[g]) * LW'(dmag_s2[g]);
			assign lprod_d[g] = LW'(side_s2[g + 1]) * LW'(side_s2[g]);
		end
	endgenerate

	// longest and shortest side
	assign max01 = (side_s2[1] > side_s2[0]) ? side_s2[1] : side_s2[0];
	assign max23 = (side_s2[3] > side_s2[2]) ? side_s2[3] : side_s2[2];
	assign min01 = (side_s2[1] < side_s2[0]) ? side_s2[1] : side_s2[0];
	assign min23 = (side_s2[3] < side_s2[2]) ? side_s2[3] : side_s2[2];

	// saturate area for the result, test the full value
	assign area_ext = CW'(area_s2);

	// stage 3
	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			dsq_s3       <= dsq_d;
			lprod_s3     <= lprod_d;
			smax_s3      <= (max23 > max01) ? max23 : max01;
			smin_s3      <= (min23 < min01) ? min23 : min01;
			area_s3      <= (area_ext > CW'(AREA_MAX)) ? AREA_MAX : area_ext[AREA_W-1:0];
			small_s3     <= area_ext < CW'(cfg.min_area2);
			conv_fail_s3 <= conv_fail_s2;
		end
	end

	// stage 4: scale by squared limits
	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			for (int k = 0; k < 3; k++) begin
				lhs_s4[k] <= HW'(dsq_s3[k]) * HW'(cfg.cos_den_sq);
				rhs_s4[k] <= HW'(lprod_s3[k]) * HW'(cfg.cos_num_sq);
			end
			rl_s4        <= RW'(smax_s3) * RW'(cfg.ratio_den_sq);
			rr_s4        <= RW'(smin_s3) * RW'(cfg.ratio_num_sq);
			area_s4      <= area_s3;
			small_s4     <= small_s3;
			conv_fail_s4 <= conv_fail_s3;
		end
	end

endmodule

// File: rtl/qsq_decide.sv
`timescale 1ns / 1ps

module qsq_decide #(
	parameter int COORD_BITS = 12
) (
	input  logic                                             clk,
	input  qsq_pkg::pipe_ctl_t                               ctl,
	input  logic [2:0][2*(2*COORD_BITS+1)+qsq_pkg::SQ_W-1:0] lhs_s4,
	input  logic [2:0][2*(2*COORD_BITS+1)+qsq_pkg::SQ_W-1:0] rhs_s4,
	input  logic [2*COORD_BITS+qsq_pkg::SQ_W:0]              rl_s4,
	input  logic [2*COORD_BITS+qsq_pkg::SQ_W:0]              rr_s4,
	input  logic [qsq_pkg::AREA_W-1:0]                       area_s4,
	input  logic                                             conv_fail_s4,
	input  logic                                             small_s4,
	output logic                                             accepted_s5,
	output qsq_pkg::reason_t                                 reason_s5,
	output logic [qsq_pkg::AREA_W-1:0]                       area_s5
);
	import qsq_pkg::*;

	logic [2:0] corner_fail;
	logic       ratio_fail;
	reason_t    reason_d;

	// compare scaled cosines and side ratio
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			corner_fail[k] = lhs_s4[k] > rhs_s4[k];
		end
		ratio_fail = rl_s4 > rr_s4;
	end

	// first failing test wins
	always_comb begin
		if (conv_fail_s4) begin
			reason_d = REASON_CONVEX;
		end else if (|corner_fail) begin
			reason_d = REASON_ANGLE;
		end else if (ratio_fail) begin
			reason_d = REASON_RATIO;
		end else if (small_s4) begin
			reason_d = REASON_SMALL;
		end else begin
			reason_d = REASON_OK;
		end
	end

	// stage 5: result register
	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			accepted_s5 <= reason_d == REASON_OK;
			reason_s5   <= reason_d;
			area_s5     <= area_s4;
		end
	end

endmodule

// File: rtl/quad_square_qualifier_core.sv
`timescale 1ns / 1ps
// An accepted quadrilateral moves through stages s1 to s5; s5 drives the result channel.
// Throughput: one quadrilateral per cycle, set by the five-stage register pipeline;
// a stalled result holds its stage, earlier stages keep filling empty slots and the
// input is held only once every stage is full.
// Reset clears the stage valid bits and returns the limit registers to their defaults.

module quad_square_qualifier_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	qsq_in_if.sink                         quad,
	qsq_out_if.source                      result
);
	import qsq_pkg::*;

	localparam int PW = 2 * COORD_BITS + 1;
	localparam int HW = 2 * PW + SQ_W;
	localparam int RW = PW + SQ_W;

	cfg_t                     cfg;
	pipe_ctl_t                ctl;
	logic [NSTAGES-1:0]       valid_q;
	logic [3:0][COORD_BITS-1:0] px, py;

	logic [3:0][PW-1:0] side_s2;
	logic [2:0][PW-1:0] dmag_s2;
	logic [PW-1:0]      area_s2;
	logic               conv_fail_s2;

	logic [2:0][HW-1:0] lhs_s4, rhs_s4;
	logic [RW-1:0]      rl_s4, rr_s4;
	logic [AREA_W-1:0]  area_s4;
	logic               conv_fail_s4, small_s4;

	logic               accepted_s5;
	reason_t            reason_s5;
	logic [AREA_W-1:0]  area_s5;

	// gather vertices
	assign px[0] = quad.x0;
	assign py[0] = quad.y0;
	assign px[1] = quad.x1;
	assign py[1] = quad.y1;
	assign px[2] = quad.x2;
	assign py[2] = quad.y2;
	assign px[3] = quad.x3;
	assign py[3] = quad.y3;

	// a stage loads when empty or when its content moves on
	always_comb begin
		ctl.adv[NSTAGES-1] = !valid_q[NSTAGES-1] || result.ready;
		for (int k = NSTAGES - 2; k >= 0; k--) begin
			ctl.adv[k] = !valid_q[k] || ctl.adv[k+1];
		end
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.adv[0]) begin
				valid_q[0] <= quad.valid;
			end
			for (int k = 1; k < NSTAGES; k++) begin
				if (ctl.adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign quad.ready = ctl.adv[0];

	qsq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	qsq_geom #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk          (clk),
		.ctl          (ctl),
		.px           (px),
		.py           (py),
		.side_s2      (side_s2),
		.dmag_s2      (dmag_s2),
		.area_s2      (area_s2),
		.conv_fail_s2 (conv_fail_s2)
	);

	qsq_prod #(.COORD_BITS(COORD_BITS)) u_prod (
		.clk          (clk),
		.ctl          (ctl),
		.cfg          (cfg),
		.side_s2      (side_s2),
		.dmag_s2      (dmag_s2),
		.area_s2      (area_s2),
		.conv_fail_s2 (conv_fail_s2),
		.lhs_s4       (lhs_s4),
		.rhs_s4       (rhs_s4),
		.rl_s4        (rl_s4),
		.rr_s4        (rr_s4),
		.area_s4      (area_s4),
		.conv_fail_s4 (conv_fail_s4),
		.small_s4     (small_s4)
	);

	qsq_decide #(.COORD_BITS(COORD_BITS)) u_decide (
		.clk          (clk),
		.ctl          (ctl),
		.lhs_s4       (lhs_s4),
		.rhs_s4       (rhs_s4),
		.rl_s4        (rl_s4),
		.rr_s4        (rr_s4),
		.area_s4      (area_s4),
		.conv_fail_s4 (conv_fail_s4),
		.small_s4     (small_s4),
		.accepted_s5  (accepted_s5),
		.reason_s5    (reason_s5),
		.area_s5      (area_s5)
	);

	// drive the result channel from the last stage
	assign result.valid         = valid_q[NSTAGES-1];
	assign result.accepted      = accepted_s5;
	assign result.reject_reason = reason_s5;
	assign result.area_doubled  = area_s5;

endmodule

// File: rtl/qsq_checker.sv
`timescale 1ns / 1ps

module qsq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          quad_valid,
	input logic                          quad_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          res_accepted,
	input logic [2:0]                    res_reason,
	input logic [qsq_pkg::AREA_W-1:0]    res_area
);
	import qsq_pkg::*;

	// accept flag agrees with the reason code
	a_accept_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_accepted == (res_reason == REASON_OK)))
		else $error("accepted flag disagrees with reject reason");

	// a taken result frees the whole pipeline for a new quadrilateral
	a_ready_passes_back: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> quad_ready)
		else $error("input stalled while result side is ready");

	// with the result side ready throughout, an accepted transaction yields a valid verdict
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(quad_valid && quad_ready && res_ready) ##1 res_ready ##1 res_ready
		##1 res_ready ##1 res_ready |=> res_valid)
		else $error("verdict missing after pipeline latency");

	// a stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_accepted)
		&& $stable(res_reason) && $stable(res_area)))
		else $error("result changed while stalled");

endmodule

bind quad_square_qualifier_core qsq_checker u_qsq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.quad_valid   (quad.valid),
	.quad_ready   (quad.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_accepted (result.accepted),
	.res_reason   (result.reject_reason),
	.res_area     (result.area_doubled)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import qsq_pkg::*;

	localparam int COORD_W     = 12;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int JUNK_W      = CFG_DATA_W - CFG_NARROW_W;

	typedef struct packed {
		logic [3:0][COORD_W-1:0] x;
		logic [3:0][COORD_W-1:0] y;
	} quad_t;

	typedef struct packed {
		logic              accepted;
		reason_t           reason;
		logic [AREA_W-1:0] area;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	qsq_in_if #(.COORD_BITS(COORD_W)) quad_ch ();
	qsq_out_if verdict_ch ();

	quad_square_qualifier_core #(.COORD_BITS(COORD_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.quad      (quad_ch),
		.result    (verdict_ch)
	);

	// limits as the block should hold them
	logic [CFG_NARROW_W-1:0] lim_cos_num   = RST_COS_NUM;
	logic [CFG_NARROW_W-1:0] lim_cos_den   = RST_COS_DEN;
	logic [CFG_NARROW_W-1:0] lim_ratio_num = RST_RATIO_NUM;
	logic [CFG_NARROW_W-1:0] lim_ratio_den = RST_RATIO_DEN;
	logic [MIN_AREA_W-1:0]   lim_min_area  = RST_MIN_AREA;

	verdict_t    pending_verdicts[$];
	bit          src_idle_on  = 1'b1;
	bit          sink_idle_on = 1'b1;
	int unsigned quads_sent;
	int unsigned verdicts_checked;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned reason_tally[5];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// track a register write in the limit copy; unknown indexes are dropped
	function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_COS_NUM:   lim_cos_num   = data[CFG_NARROW_W-1:0];
			REG_COS_DEN:   lim_cos_den   = data[CFG_NARROW_W-1:0];
			REG_RATIO_NUM: lim_ratio_num = data[CFG_NARROW_W-1:0];
			REG_RATIO_DEN: lim_ratio_den = data[CFG_NARROW_W-1:0];
			REG_MIN_AREA:  lim_min_area  = data[MIN_AREA_W-1:0];
			default: ;
		endcase
	endfunction

	// true when the corner cosine exceeds the limit, compared on exact squares
	function automatic bit corner_too_sharp(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint       dot;
		logic [127:0] dot_mag, len_a, len_b, cn, cd, lhs, rhs;
		dot     = ax * bx + ay * by;
		dot_mag = 128'((dot < 0) ? -dot : dot);
		len_a   = 128'(ax * ax + ay * ay);
		len_b   = 128'(bx * bx + by * by);
		cn      = 128'(lim_cos_num);
		cd      = 128'(lim_cos_den);
		lhs     = (dot_mag * cd) * (dot_mag * cd);
		rhs     = cn * cn * len_a * len_b;
		return lhs > rhs;
	endfunction

	// work out the verdict for one quadrilateral under the current limits
	function automatic verdict_t judge_quad(input quad_t q);
		longint       px[4], py[4];
		longint       ex0, ey0, ex1, ey1, turn, shoe, dx, dy;
		logic [127:0] side, side_max, side_min, area2, rn, rd, floor2;
		bit           turn_pos, turn_neg;
		int           i;
		verdict_t     v;
		turn_pos = 1'b0;
		turn_neg = 1'b0;
		shoe     = 0;
		side_max = '0;
		side_min = '0;
		for (i = 0; i < 4; i++) begin
			px[i] = longint'(q.x[i]);
			py[i] = longint'(q.y[i]);
		end
		// turn direction at each vertex, and the shoelace sum
		for (i = 0; i < 4; i++) begin
			ex0  = px[(i + 3) % 4] - px[(i + 2) % 4];
			ey0  = py[(i + 3) % 4] - py[(i + 2) % 4];
			ex1  = px[i] - px[(i + 3) % 4];
			ey1  = py[i] - py[(i + 3) % 4];
			turn = ex0 * ey1 - ey0 * ex1;
			if (turn > 0)
				turn_pos = 1'b1;
			if (turn < 0)
				turn_neg = 1'b1;
			shoe += px[i] * py[(i + 1) % 4] - px[(i + 1) % 4] * py[i];
		end
		area2 = 128'((shoe < 0) ? -shoe : shoe);
		// longest and shortest squared side
		for (i = 0; i < 4; i++) begin
			dx   = px[(i + 1) % 4] - px[i];
			dy   = py[(i + 1) % 4] - py[i];
			side = 128'(dx * dx + dy * dy);
			if (i == 0 || side > side_max)
				side_max = side;
			if (i == 0 || side < side_min)
				side_min = side;
		end
		rn     = 128'(lim_ratio_num);
		rd     = 128'(lim_ratio_den);
		floor2 = 128'(lim_min_area);
		floor2 = floor2 * 2;
		// first failing test wins; vertex 0 has no corner test
		if (turn_pos && turn_neg)
			v.reason = REASON_CONVEX;
		else if (corner_too_sharp(px[2] - px[1], py[2] - py[1], px[0] - px[1], py[0] - py[1]) ||
				corner_too_sharp(px[3] - px[2], py[3] - py[2], px[1] - px[2], py[1] - py[2]) ||
				corner_too_sharp(px[0] - px[3], py[0] - py[3], px[2] - px[3], py[2] - py[3]))
			v.reason = REASON_ANGLE;
		else if (side_max * rd * rd > rn * rn * side_min)
			v.reason = REASON_RATIO;
		else if (area2 < floor2)
			v.reason = REASON_SMALL;
		else
			v.reason = REASON_OK;
		v.accepted = (v.reason == REASON_OK);
		v.area     = (area2 > AREA_MAX) ? AREA_MAX : area2[AREA_W-1:0];
		return v;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return COORD_MAX[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	function automatic quad_t quad_of(input int ax, input int ay, input int bx, input int by,
			input int cx, input int cy, input int dx, input int dy);
		quad_t q;
		q.x[0] = clamp_coord(ax);
		q.y[0] = clamp_coord(ay);
		q.x[1] = clamp_coord(bx);
		q.y[1] = clamp_coord(by);
		q.x[2] = clamp_coord(cx);
		q.y[2] = clamp_coord(cy);
		q.x[3] = clamp_coord(dx);
		q.y[3] = clamp_coord(dy);
		return q;
	endfunction

	// rectangle or square at a random angle, with optional stretch and wobble
	function automatic quad_t near_square(input int span, input int jitter);
		int    a, b, wx, wy, st, reach, cx, cy, wob, rot, i;
		int    ox[4], oy[4];
		quad_t raw, q;
		a     = $urandom_range(0, span);
		b     = $urandom_range(0, span);
		st    = ($urandom_range(2) == 0) ? $urandom_range(12, 20) : 16;
		wx    = -((b * st) / 16);
		wy    = (a * st) / 16;
		reach = (9 * (a + b)) / 4 + jitter;
		cx    = $urandom_range(reach, COORD_MAX - reach);
		cy    = $urandom_range(reach, COORD_MAX - reach);
		ox[0] = a + wx;
		oy[0] = b + wy;
		ox[1] = wx - a;
		oy[1] = wy - b;
		ox[2] = -a - wx;
		oy[2] = -b - wy;
		ox[3] = a - wx;
		oy[3] = b - wy;
		for (i = 0; i < 4; i++) begin
			wob = $urandom_range(0, 2 * jitter);
			raw.x[i] = clamp_coord(cx + ox[i] + wob - jitter);
			wob = $urandom_range(0, 2 * jitter);
			raw.y[i] = clamp_coord(cy + oy[i] + wob - jitter);
		end
		// flip the winding now and then, and start at any corner
		if ($urandom_range(1)) begin
			q = raw;
			raw.x[1] = q.x[3];
			raw.y[1] = q.y[3];
			raw.x[3] = q.x[1];
			raw.y[3] = q.y[1];
		end
		rot = $urandom_range(3);
		for (i = 0; i < 4; i++) begin
			q.x[i] = raw.x[(i + rot) % 4];
			q.y[i] = raw.y[(i + rot) % 4];
		end
		return q;
	endfunction

	// mostly well-formed candidates, with free noise and degenerate shapes mixed in
	function automatic quad_t random_quad();
		int    pick, k, bx, by, sx, sy, span;
		quad_t q;
		pick = $urandom_range(99);
		span = ($urandom_range(3) == 0) ? $urandom_range(5, 400) : $urandom_range(5, 120);
		if (pick < 70) begin
			q = near_square(span, $urandom_range(0, span / 8));
		end else if (pick < 85) begin
			for (k = 0; k < 4; k++) begin
				q.x[k] = COORD_W'($urandom_range(0, COORD_MAX));
				q.y[k] = COORD_W'($urandom_range(0, COORD_MAX));
			end
		end else if (pick < 93) begin
			// coincident neighbours
			q = near_square(span, 0);
			k = $urandom_range(3);
			q.x[(k + 1) % 4] = q.x[k];
			q.y[(k + 1) % 4] = q.y[k];
		end else begin
			// all four on one line
			bx = $urandom_range(0, 1000);
			by = $urandom_range(0, 1000);
			sx = $urandom_range(0, 300);
			sy = $urandom_range(0, 300);
			for (k = 0; k < 4; k++) begin
				q.x[k] = clamp_coord(bx + k * sx);
				q.y[k] = clamp_coord(by + k * sy);
			end
		end
		return q;
	endfunction

	// offer one quadrilateral, hold it until taken, then record its verdict
	task automatic send_quad(input quad_t q);
		while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
			quad_ch.valid <= 1'b0;
			@(posedge clk);
		end
		quad_ch.valid <= 1'b1;
		quad_ch.x0    <= q.x[0];
		quad_ch.y0    <= q.y[0];
		quad_ch.x1    <= q.x[1];
		quad_ch.y1    <= q.y[1];
		quad_ch.x2    <= q.x[2];
		quad_ch.y2    <= q.y[2];
		quad_ch.x3    <= q.x[3];
		quad_ch.y3    <= q.y[3];
		@(posedge clk);
		while (!quad_ch.ready)
			@(posedge clk);
		pending_verdicts.insert(pending_verdicts.size(), judge_quad(q));
		quads_sent++;
	endtask

	// stop offering and hold until every verdict is back
	task automatic wait_for_verdicts();
		quad_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		note_reg_write(idx, data);
		@(posedge clk);
	endtask

	// write all five limits; spare upper bits of the narrow ones carry junk
	task automatic write_limits(input logic [CFG_NARROW_W-1:0] cn, input logic [CFG_NARROW_W-1:0] cd,
			input logic [CFG_NARROW_W-1:0] rn, input logic [CFG_NARROW_W-1:0] rd,
			input logic [MIN_AREA_W-1:0] ma);
		logic [JUNK_W-1:0] junk;
		wait_for_verdicts();
		junk = JUNK_W'($urandom);
		put_reg(REG_COS_NUM, {junk, cn});
		junk = JUNK_W'($urandom);
		put_reg(REG_COS_DEN, {junk, cd});
		junk = JUNK_W'($urandom);
		put_reg(REG_RATIO_NUM, {junk, rn});
		junk = JUNK_W'($urandom);
		put_reg(REG_RATIO_DEN, {junk, rd});
		put_reg(REG_MIN_AREA, ma);
		cfg_we <= 1'b0;
	endtask

	// reset limits: one of each verdict plus the degenerate shapes
	task automatic test_reset_defaults();
		send_quad(quad_of(100, 100, 300, 100, 300, 300, 100, 300));
		send_quad(quad_of(100, 300, 300, 300, 300, 100, 100, 100));
		send_quad(quad_of(10, 10, 20, 10, 20, 20, 10, 20));
		send_quad(quad_of(100, 100, 250, 100, 250, 200, 100, 200));
		send_quad(quad_of(0, 0, 200, 0, 300, 200, 100, 200));
		send_quad(quad_of(0, 0, 400, 200, 0, 400, 150, 200));
		send_quad(quad_of(0, 0, 400, 400, 400, 0, 0, 400));
		send_quad(quad_of(0, 0, 0, 0, 0, 0, 0, 0));
		send_quad(quad_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_quad(quad_of(0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX));
		send_quad(quad_of(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
		send_quad(quad_of(0, 0, 100, 0, 200, 0, 300, 0));
		send_quad(quad_of(100, 100, 100, 100, 300, 100, 100, 300));
		send_quad(quad_of(500, 300, 800, 500, 600, 800, 300, 600));
		send_quad(quad_of(1000, 1000, 1040, 1000, 1040, 1041, 1000, 1040));
		send_quad(quad_of(2000, 2000, 2100, 2000, 2100, 2000, 2000, 2100));
		wait_for_verdicts();
	endtask

	// limits at their edges, zero denominators and zero numerators among them
	task automatic test_limit_extremes();
		logic [CFG_NARROW_W-1:0] cn[6], cd[6], rn[6], rd[6];
		logic [MIN_AREA_W-1:0]   ma[6];
		int                      s, n;
		cn[0] = 8'd0;   cd[0] = 8'd255; rn[0] = 8'd255; rd[0] = 8'd1;   ma[0] = '0;
		cn[1] = 8'd255; cd[1] = 8'd1;   rn[1] = 8'd0;   rd[1] = 8'd255; ma[1] = '1;
		cn[2] = 8'd255; cd[2] = 8'd0;   rn[2] = 8'd255; rd[2] = 8'd0;   ma[2] = '0;
		cn[3] = 8'd255; cd[3] = 8'd255; rn[3] = 8'd1;   rd[3] = 8'd1;   ma[3] = 24'd1;
		cn[4] = 8'd1;   cd[4] = 8'd4;   rn[4] = 8'd6;   rd[4] = 8'd5;   ma[4] = '1;
		cn[5] = 8'd0;   cd[5] = 8'd1;   rn[5] = 8'd1;   rd[5] = 8'd255; ma[5] = '0;
		for (s = 0; s < 6; s++) begin
			write_limits(cn[s], cd[s], rn[s], rd[s], ma[s]);
			send_quad(quad_of(0, 0, 0, 0, 0, 0, 0, 0));
			send_quad(quad_of(500, 300, 800, 500, 600, 800, 300, 600));
			for (n = 0; n < 8; n++)
				send_quad(random_quad());
		end
		wait_for_verdicts();
	endtask

	// writes to indexes past the last register must change nothing
	task automatic test_unknown_index();
		int k, n;
		write_limits(RST_COS_NUM, RST_COS_DEN, RST_RATIO_NUM, RST_RATIO_DEN, RST_MIN_AREA);
		for (k = int'(REG_MIN_AREA) + 1; k < (1 << CFG_IDX_W); k++)
			put_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		for (n = 0; n < 20; n++)
			send_quad(random_quad());
		wait_for_verdicts();
	endtask

	// random candidates over several limit settings, with a pause mid-phase in the first and at random in the rest
	task automatic test_random_mix();
		logic [CFG_NARROW_W-1:0] cn, cd, rn, rd;
		logic [MIN_AREA_W-1:0]   ma;
		int                      p, n;
		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_limits(RST_COS_NUM, RST_COS_DEN, RST_RATIO_NUM, RST_RATIO_DEN,
					RST_MIN_AREA);
				1: write_limits(8'd1, 8'd2, 8'd3, 8'd2, 24'd100);
				2: write_limits(8'd1, 8'd20, 8'd21, 8'd20, 24'd5000);
				default: begin
					cd = CFG_NARROW_W'($urandom_range(1, 255));
					cn = CFG_NARROW_W'($urandom_range(0, cd));
					rd = CFG_NARROW_W'($urandom_range(1, 255));
					rn = CFG_NARROW_W'($urandom_range(rd, 255));
					ma = MIN_AREA_W'(($urandom_range(3) == 0)
						? $urandom_range(0, (1 << MIN_AREA_W) - 1)
						: $urandom_range(0, 20000));
					write_limits(cn, cd, rn, rd, ma);
				end
			endcase
			for (n = 0; n < 90; n++) begin
				if (n == 45 && (p == 0 || $urandom_range(1)))
					wait_for_verdicts();
				send_quad(random_quad());
			end
		end
		wait_for_verdicts();
	endtask

	// back-to-back transactions with neither side idling
	task automatic test_back_to_back();
		int n;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		for (n = 0; n < 150; n++)
			send_quad(random_quad());
		wait_for_verdicts();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// take each verdict and compare it with the oldest one predicted
	initial begin : verdict_checker
		verdict_t want;
		verdict_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (verdict_ch.valid && verdict_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					error_count++;
					$display("%0t ns: verdict with none expected: accepted %0d reason %0d area %0d",
						$time, verdict_ch.accepted, verdict_ch.reject_reason,
						verdict_ch.area_doubled);
				end else begin
					want = pending_verdicts.pop_front();
					verdicts_checked++;
					reason_tally[want.reason]++;
					if (verdict_ch.accepted !== want.accepted) begin
						error_count++;
						$display("%0t ns: accepted expected %0d got %0d",
							$time, want.accepted, verdict_ch.accepted);
					end
					if (verdict_ch.reject_reason !== want.reason) begin
						error_count++;
						$display("%0t ns: reject_reason expected %0d got %0d",
							$time, want.reason, verdict_ch.reject_reason);
					end
					if (verdict_ch.area_doubled !== want.area) begin
						error_count++;
						$display("%0t ns: area_doubled expected %0d got %0d",
							$time, want.area, verdict_ch.area_doubled);
					end
				end
			end
			verdict_ch.ready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// end the run if it hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t ns: cycle limit reached with %0d verdicts outstanding",
			$time, pending_verdicts.size());
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		quad_ch.valid = 1'b0;
		quad_ch.x0    = '0;
		quad_ch.y0    = '0;
		quad_ch.x1    = '0;
		quad_ch.y1    = '0;
		quad_ch.x2    = '0;
		quad_ch.y2    = '0;
		quad_ch.x3    = '0;
		quad_ch.y3    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_limit_extremes();
		test_unknown_index();
		test_random_mix();
		test_back_to_back();

		// drain, then watch a while longer for stray verdicts
		wait_for_verdicts();
		repeat (4 * NSTAGES) @(posedge clk);

		$display("testbench: %0d quads, %0d verdicts checked over reset, edge and random limits",
			quads_sent, verdicts_checked);
		$display("testbench: ok %0d, not convex %0d, angle %0d, side ratio %0d, too small %0d",
			reason_tally[REASON_OK], reason_tally[REASON_CONVEX], reason_tally[REASON_ANGLE],
			reason_tally[REASON_RATIO], reason_tally[REASON_SMALL]);
		if (error_count == 0 && pending_verdicts.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
